// File: hw/rtl/bfd_pkg.sv
// Shared types and constants for the box filter image downscaler.
// No dependencies; every other file of the block imports this package.
package bfd_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int SIZE_W     = 13;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int SUM_W      = 32;
    localparam int CNT_W      = 25;
    localparam int PIX_W      = 8;
    localparam int QBIT_W     = $clog2(PIX_W);
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

    localparam logic [SIZE_W-1:0] RST_SRC_WIDTH  = 13'd640;
    localparam logic [SIZE_W-1:0] RST_SRC_HEIGHT = 13'd480;
    localparam logic [SIZE_W-1:0] RST_DST_WIDTH  = 13'd320;
    localparam logic [SIZE_W-1:0] RST_DST_HEIGHT = 13'd240;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_DIV,
        S_PUSH
    } state_t;

    typedef struct packed {
        logic take;
        logic update;
        logic div_step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic box_close;
        logic div_last;
        logic out_full;
    } dp_status_t;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
        logic [CNT_W-1:0] count;
    } entry_t;

endpackage

// File: hw/rtl/bfd_if.sv
// Valid/ready channel interfaces for source pixels and averaged pixels.
// Depends on bfd_pkg for the component width.
interface bfd_in_if import bfd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;

    modport source (output valid, red_in, green_in, blue_in, input ready);
    modport sink (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface bfd_out_if import bfd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic             row_end;
    logic             frame_end;

    modport source (output valid, red_out, green_out, blue_out, row_end, frame_end,
                    input ready);
    modport sink (input valid, red_out, green_out, blue_out, row_end, frame_end,
                  output ready);
endinterface

// File: hw/rtl/bfd_ctrl.sv
// Controller state machine of the downscaler.
// Depends on bfd_pkg; drives the datapath through ctrl_cmd_t.
module bfd_ctrl import bfd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                state_next = status.box_close ? S_DIV : S_IDLE;
            end
            S_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (!status.out_full)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            S_PUSH:
            begin
                cmd.out_load = !status.out_full;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: hw/rtl/bfd_datapath.sv
// Datapath of the downscaler: size registers, position counters, sum memory,
// shared restoring divider and output register. Depends on bfd_pkg.
module bfd_datapath import bfd_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctrl_cmd_t            cmd,
    output dp_status_t           status,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    input  logic [PIX_W-1:0]     red_in,
    input  logic [PIX_W-1:0]     green_in,
    input  logic [PIX_W-1:0]     blue_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [PIX_W-1:0]     red_out,
    output logic [PIX_W-1:0]     green_out,
    output logic [PIX_W-1:0]     blue_out,
    output logic                 row_end,
    output logic                 frame_end
);

    logic [SIZE_W-1:0] src_width_reg, src_height_reg, dst_width_reg, dst_height_reg;
    logic [SIZE_W-1:0] sw, sh, dw, dh;

    logic [COL_W-1:0]  scol_reg, ocol_reg;
    logic [ROW_W-1:0]  srow_reg, orow_reg;

    // The accumulators hold column * dst - box * src, which is above -dst
    // and at most src - dst, so they are signed.
    logic signed [SIZE_W+1:0] cacc_reg, racc_reg;
    logic signed [SIZE_W+1:0] cacc_sum, racc_sum;
    logic signed [SIZE_W+1:0] sw_x, sh_x, dw_x, dh_x;
    logic              col_close, row_close, first_pix, last_col, last_row;
    logic [SIZE_W-1:0] scol_inc;
    logic [SIZE_W:0]   srow_inc;

    entry_t            mem [MAX_WIDTH];
    entry_t            rd_reg;
    entry_t            upd;
    logic [PIX_W-1:0]  red_reg, green_reg, blue_reg;

    logic [SUM_W-1:0]  rem_reg [3];
    logic [SUM_W-1:0]  rem_next [3];
    logic [PIX_W-1:0]  quo_reg [3];
    logic [PIX_W-1:0]  quo_next [3];
    logic [CNT_W-1:0]  div_reg;
    logic [QBIT_W-1:0] bit_reg;
    logic [SUM_W:0]    trial;
    logic              row_end_reg, frame_end_reg;

    logic              out_full_reg;
    logic [PIX_W-1:0]  red_out_reg, green_out_reg, blue_out_reg;
    logic              row_end_out_reg, frame_end_out_reg;

    always_comb
    begin
        if (src_width_reg == '0)
            sw = SIZE_W'(1);
        else if (src_width_reg > SIZE_W'(MAX_WIDTH))
            sw = SIZE_W'(MAX_WIDTH);
        else
            sw = src_width_reg;
        if (src_height_reg == '0)
            sh = SIZE_W'(1);
        else if (src_height_reg > SIZE_W'(MAX_HEIGHT))
            sh = SIZE_W'(MAX_HEIGHT);
        else
            sh = src_height_reg;
        if (dst_width_reg == '0)
            dw = SIZE_W'(1);
        else if (dst_width_reg > sw)
            dw = sw;
        else
            dw = dst_width_reg;
        if (dst_height_reg == '0)
            dh = SIZE_W'(1);
        else if (dst_height_reg > sh)
            dh = sh;
        else
            dh = dst_height_reg;
    end

    assign sw_x      = $signed({2'b00, sw});
    assign sh_x      = $signed({2'b00, sh});
    assign dw_x      = $signed({2'b00, dw});
    assign dh_x      = $signed({2'b00, dh});
    assign cacc_sum  = cacc_reg + dw_x;
    assign racc_sum  = racc_reg + dh_x;
    assign col_close = ((cacc_sum + dw_x) > sw_x);
    assign row_close = ((racc_sum + dh_x) > sh_x);
    assign first_pix = (cacc_reg[SIZE_W+1] || (cacc_reg == '0)) &&
                       (racc_reg[SIZE_W+1] || (racc_reg == '0));
    assign last_col  = ({1'b0, ocol_reg} + SIZE_W'(1)) >= dw;
    assign last_row  = ({1'b0, orow_reg} + SIZE_W'(1)) >= dh;
    assign scol_inc  = {1'b0, scol_reg} + SIZE_W'(1);
    assign srow_inc  = {2'b0, srow_reg} + (SIZE_W + 1)'(1);

    always_comb
    begin
        if (first_pix)
        begin
            upd.red   = SUM_W'(red_reg);
            upd.green = SUM_W'(green_reg);
            upd.blue  = SUM_W'(blue_reg);
            upd.count = CNT_W'(1);
        end
        else
        begin
            upd.red   = rd_reg.red + SUM_W'(red_reg);
            upd.green = rd_reg.green + SUM_W'(green_reg);
            upd.blue  = rd_reg.blue + SUM_W'(blue_reg);
            upd.count = rd_reg.count + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            rd_reg    <= mem[ocol_reg];
            red_reg   <= red_in;
            green_reg <= green_in;
            blue_reg  <= blue_in;
        end
        if (cmd.update)
        begin
            mem[ocol_reg] <= upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= RST_SRC_WIDTH;
            src_height_reg <= RST_SRC_HEIGHT;
            dst_width_reg  <= RST_DST_WIDTH;
            dst_height_reg <= RST_DST_HEIGHT;
            scol_reg       <= '0;
            srow_reg       <= '0;
            ocol_reg       <= '0;
            orow_reg       <= '0;
            cacc_reg       <= '0;
            racc_reg       <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SRC_WIDTH:  src_width_reg  <= cfg_data;
                REG_SRC_HEIGHT: src_height_reg <= cfg_data;
                REG_DST_WIDTH:  dst_width_reg  <= cfg_data;
                REG_DST_HEIGHT: dst_height_reg <= cfg_data;
                default:        src_width_reg  <= src_width_reg;
            endcase
            scol_reg <= '0;
            srow_reg <= '0;
            ocol_reg <= '0;
            orow_reg <= '0;
            cacc_reg <= '0;
            racc_reg <= '0;
        end
        else if (cmd.update)
        begin
            if (scol_inc >= sw)
            begin
                scol_reg <= '0;
                ocol_reg <= '0;
                cacc_reg <= '0;
                if (srow_inc >= {1'b0, sh})
                begin
                    srow_reg <= '0;
                    orow_reg <= '0;
                    racc_reg <= '0;
                end
                else
                begin
                    srow_reg <= srow_inc[ROW_W-1:0];
                    if (row_close)
                    begin
                        orow_reg <= orow_reg + ROW_W'(1);
                        racc_reg <= racc_sum - sh_x;
                    end
                    else
                    begin
                        racc_reg <= racc_sum;
                    end
                end
            end
            else
            begin
                scol_reg <= scol_inc[COL_W-1:0];
                if (col_close)
                begin
                    ocol_reg <= ocol_reg + COL_W'(1);
                    cacc_reg <= cacc_sum - sw_x;
                end
                else
                begin
                    cacc_reg <= cacc_sum;
                end
            end
        end
    end

    assign trial = {(SUM_W + 1 - CNT_W)'(0), div_reg} << bit_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rem_next[i] = rem_reg[i];
            quo_next[i] = quo_reg[i];
            if ({1'b0, rem_reg[i]} >= trial)
            begin
                rem_next[i]          = rem_reg[i] - trial[SUM_W-1:0];
                quo_next[i][bit_reg] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            rem_reg[0]    <= upd.red;
            rem_reg[1]    <= upd.green;
            rem_reg[2]    <= upd.blue;
            quo_reg[0]    <= '0;
            quo_reg[1]    <= '0;
            quo_reg[2]    <= '0;
            div_reg       <= upd.count;
            row_end_reg   <= last_col;
            frame_end_reg <= last_col && last_row;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= '1;
        end
        else if (cmd.update)
        begin
            bit_reg <= '1;
        end
        else if (cmd.div_step)
        begin
            bit_reg <= bit_reg - QBIT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_full_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_full_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            red_out_reg       <= quo_reg[0];
            green_out_reg     <= quo_reg[1];
            blue_out_reg      <= quo_reg[2];
            row_end_out_reg   <= row_end_reg;
            frame_end_out_reg <= frame_end_reg;
        end
    end

    assign status.box_close = col_close && row_close;
    assign status.div_last  = (bit_reg == '0);
    assign status.out_full  = out_full_reg;

    assign out_valid = out_full_reg;
    assign red_out   = red_out_reg;
    assign green_out = green_out_reg;
    assign blue_out  = blue_out_reg;
    assign row_end   = row_end_out_reg;
    assign frame_end = frame_end_out_reg;

endmodule

// File: hw/rtl/box_filter_image_downscaler.sv
// Box filter (area average) RGB image downscaler, top level.
// Depends on bfd_pkg, bfd_if, bfd_ctrl and bfd_datapath.
//
// Source pixels enter on pix_in in raster order, one transaction per pixel.
// Averaged output pixels leave on pix_out, one transaction per output pixel,
// with row_end on the last pixel of an output row and frame_end on the last
// pixel of the image. Sizes are set through the write port (cfg_we,
// cfg_index, cfg_data); any write restarts the frame at source pixel (0,0).
// The user must make writes only while no pixel is being processed; the block
// itself does not enforce this. A pixel that closes no box is accepted, then
// its sum memory entry is updated. A pixel that closes a box then also goes
// through the divider, which resolves one quotient bit per cycle for all three
// channels, and is then loaded into the output register to raise pix_out.valid.
// The output register holds the result while the receiver stalls, and the
// next pixel is accepted meanwhile; a further result waits in the divider
// until the register is free. Reset restores the default sizes of 640x480
// to 320x240 and restarts the frame; the sum memory needs no clearing, as
// the first pixel of each box overwrites its entry.
module box_filter_image_downscaler import bfd_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    bfd_in_if.sink               pix_in,
    bfd_out_if.source            pix_out,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    bfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pix_in.valid),
        .in_ready (pix_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    bfd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .red_in    (pix_in.red_in),
        .green_in  (pix_in.green_in),
        .blue_in   (pix_in.blue_in),
        .out_valid (pix_out.valid),
        .out_ready (pix_out.ready),
        .red_out   (pix_out.red_out),
        .green_out (pix_out.green_out),
        .blue_out  (pix_out.blue_out),
        .row_end   (pix_out.row_end),
        .frame_end (pix_out.frame_end)
    );

endmodule

// File: verif/box_filter_image_downscaler_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the box filter image downscaler.
// Depends on bfd_pkg, bfd_if and the RTL; predicts each averaged pixel and compares it.
module testbench;
    import bfd_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             row_end;
        logic             frame_end;
    } avg_pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_SRC_WIDTH;
    logic [SIZE_W-1:0] cfg_data = '0;

    bfd_in_if pix_in ();
    bfd_out_if pix_out ();

    box_filter_image_downscaler DUT (
        .clk(clk), .rst_n(rst_n), .pix_in(pix_in.sink), .pix_out(pix_out.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Predictor state.
    logic [SIZE_W-1:0] size_reg [4];
    logic [SUM_W-1:0] red_acc [MAX_WIDTH];
    logic [SUM_W-1:0] green_acc [MAX_WIDTH];
    logic [SUM_W-1:0] blue_acc [MAX_WIDTH];
    logic [CNT_W-1:0] pix_count [MAX_WIDTH];
    int unsigned src_col, src_row, box_col, band_row, col_limit, row_limit;
    avg_pixel_t expected_pixels [$];
    int errors = 0;
    bit calm = 1'b0;
    bit hold_off = 1'b0;

    function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned eff_sw();
        return clamp_size(size_reg[REG_SRC_WIDTH], MAX_WIDTH);
    endfunction
    function automatic int unsigned eff_sh();
        return clamp_size(size_reg[REG_SRC_HEIGHT], MAX_HEIGHT);
    endfunction
    function automatic int unsigned eff_dw();
        return clamp_size(size_reg[REG_DST_WIDTH], eff_sw());
    endfunction
    function automatic int unsigned eff_dh();
        return clamp_size(size_reg[REG_DST_HEIGHT], eff_sh());
    endfunction

    function automatic int unsigned box_edge(int unsigned k, int unsigned s, int unsigned d);
        longint unsigned p;
        p = longint'(k) * longint'(s);
        return int'(p / d);
    endfunction

    function automatic void restart_frame();
        src_col = 0;
        src_row = 0;
        box_col = 0;
        band_row = 0;
        col_limit = box_edge(1, eff_sw(), eff_dw());
        row_limit = box_edge(1, eff_sh(), eff_dh());
    endfunction

    function automatic void predict_average(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                            logic [PIX_W-1:0] b);
        int unsigned sw, sh, dw, dh, i;
        bit first, col_close, row_close, last_col;
        avg_pixel_t p;
        sw = eff_sw();
        sh = eff_sh();
        dw = eff_dw();
        dh = eff_dh();
        i = (box_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : box_col;
        first = (src_row == box_edge(band_row, sh, dh)) &&
                (src_col == box_edge(box_col, sw, dw));
        col_close = (src_col + 1 >= col_limit);
        row_close = (src_row + 1 >= row_limit);
        if (first)
        begin
            red_acc[i] = SUM_W'(r);
            green_acc[i] = SUM_W'(g);
            blue_acc[i] = SUM_W'(b);
            pix_count[i] = CNT_W'(1);
        end
        else
        begin
            red_acc[i] += SUM_W'(r);
            green_acc[i] += SUM_W'(g);
            blue_acc[i] += SUM_W'(b);
            pix_count[i] += CNT_W'(1);
        end
        if (col_close && row_close)
        begin
            last_col = (box_col + 1 >= dw);
            p.red = (pix_count[i] != 0) ? PIX_W'(red_acc[i] / pix_count[i]) : '0;
            p.green = (pix_count[i] != 0) ? PIX_W'(green_acc[i] / pix_count[i]) : '0;
            p.blue = (pix_count[i] != 0) ? PIX_W'(blue_acc[i] / pix_count[i]) : '0;
            p.row_end = last_col;
            p.frame_end = last_col && (band_row + 1 >= dh);
            expected_pixels.push_back(p);
        end
        if (col_close)
        begin
            box_col++;
            col_limit = box_edge(box_col + 1, sw, dw);
        end
        src_col++;
        if (src_col >= sw)
        begin
            src_col = 0;
            box_col = 0;
            col_limit = box_edge(1, sw, dw);
            if (row_close)
            begin
                band_row++;
                row_limit = box_edge(band_row + 1, sh, dh);
            end
            src_row++;
            if (src_row >= sh)
            begin
                src_row = 0;
                band_row = 0;
                row_limit = box_edge(1, sh, dh);
            end
        end
    endfunction

    initial
    begin
        pix_in.valid = 1'b0;
        pix_in.red_in = '0;
        pix_in.green_in = '0;
        pix_in.blue_in = '0;
        size_reg[REG_SRC_WIDTH] = RST_SRC_WIDTH;
        size_reg[REG_SRC_HEIGHT] = RST_SRC_HEIGHT;
        size_reg[REG_DST_WIDTH] = RST_DST_WIDTH;
        size_reg[REG_DST_HEIGHT] = RST_DST_HEIGHT;
        restart_frame();
    end

    task automatic send_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            pix_in.valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
        end
        pix_in.valid <= 1'b1;
        pix_in.red_in <= r;
        pix_in.green_in <= g;
        pix_in.blue_in <= b;
        @(posedge clk);
        while (!pix_in.ready) @(posedge clk);
        predict_average(r, g, b);
    endtask

    task automatic stop_sending();
        pix_in.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_size(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        size_reg[idx] = v;
        restart_frame();
        @(posedge clk);
    endtask

    task automatic set_sizes(int sw, int sh, int dw, int dh);
        stop_sending();
        wait_drained();
        write_size(REG_SRC_WIDTH, SIZE_W'(sw));
        write_size(REG_SRC_HEIGHT, SIZE_W'(sh));
        write_size(REG_DST_WIDTH, SIZE_W'(dw));
        write_size(REG_DST_HEIGHT, SIZE_W'(dh));
    endtask

    task automatic send_random(int n);
        repeat (n) send_pixel(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
    endtask

    // Receiver with random stalls, always ready when calm, or a long hold-off on request.
    always @(posedge clk)
    begin
        if (!rst_n || hold_off)
            pix_out.ready <= 1'b0;
        else if (calm)
            pix_out.ready <= 1'b1;
        else
            pix_out.ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        avg_pixel_t want;
        if (rst_n && pix_out.valid && pix_out.ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected transaction, actual %h %h %h %b %b", $time,
                         pix_out.red_out, pix_out.green_out, pix_out.blue_out,
                         pix_out.row_end, pix_out.frame_end);
                errors++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (want != {pix_out.red_out, pix_out.green_out, pix_out.blue_out,
                             pix_out.row_end, pix_out.frame_end})
                begin
                    $display("%0t: mismatch, expected %h %h %h %b %b, actual %h %h %h %b %b",
                             $time, want.red, want.green, want.blue, want.row_end,
                             want.frame_end, pix_out.red_out, pix_out.green_out,
                             pix_out.blue_out, pix_out.row_end, pix_out.frame_end);
                    errors++;
                end
            end
        end
    end

    task automatic test_extremes();
        set_sizes(4, 2, 2, 1);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'h00, 8'hAA);
        send_pixel(8'h00, 8'hFF, 8'h55);
        send_pixel(8'h01, 8'h02, 8'h03);
        send_pixel(8'hFE, 8'hFD, 8'hFC);
        send_pixel(8'h80, 8'h7F, 8'h00);
    endtask

    task automatic test_clamping();
        set_sizes(0, 0, 0, 0);
        send_random(3);
        set_sizes(3, 2, 9, 8191);
        send_random(12);
    endtask

    task automatic test_register_restart();
        set_sizes(5, 3, 2, 2);
        send_random(4);
        stop_sending();
        wait_drained();
        write_size(REG_DST_WIDTH, SIZE_W'(3));
        send_random(15);
    endtask

    task automatic test_wide_row();
        set_sizes(4096, 1, 4096, 1);
        send_random(300);
        set_sizes(8191, 2, 1, 1);
        send_random(40);
    endtask

    task automatic test_back_pressure();
        set_sizes(4, 4, 4, 4);
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
            end
            send_random(40);
        join
    endtask

    task automatic test_random_frames();
        int k;
        for (k = 0; k < 20; k++)
        begin
            set_sizes($urandom_range(1, 12), $urandom_range(1, 8),
                      $urandom_range(0, 13), $urandom_range(0, 9));
            send_random($urandom_range(20, 80));
        end
        set_sizes(7, 5, 3, 2);
        calm = 1'b1;
        send_random(100);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_random(30);
        test_extremes();
        test_clamping();
        test_register_restart();
        test_wide_row();
        test_back_pressure();
        test_random_frames();
        stop_sending();
        wait_drained();
        if (errors == 0)
            $display("** box_filter_image_downscaler: PASSED **");
        else
            $display("** box_filter_image_downscaler: FAILED **");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("** box_filter_image_downscaler: FAILED **");
        $finish;
    end
endmodule
